// File: sv/rqsm_pkg.sv
// Shared types, field widths and codes for the run queue slot manager.
package rqsm_pkg;

  localparam int TAG_W    = 32;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;
  localparam int HND_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 5;
  localparam int ACT_W    = 5;
  localparam int ACT_RESET = 16;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             prepend;
    logic             cancellable;
    logic [TAG_W-1:0] work_tag;
    logic [HND_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  out_tag;
    logic              wake;
    logic [CNT_W-1:0]  pending_count;
  } res_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUB  = 7'b0000010,
    S_POP  = 7'b0000100,
    S_CAN1 = 7'b0001000,
    S_CAN2 = 7'b0010000,
    S_CAN3 = 7'b0100000,
    S_NOP  = 7'b1000000
  } state_t;

endpackage

// File: sv/rqsm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rqsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rqsm_ctrl.sv
// Request sequencer: list heads, fill count and read-modify-write of the slot memories.
module rqsm_ctrl
  import rqsm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [ACT_W-1:0]                     cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  req_t                                 in_req,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output res_t                                 res,
  output logic                                 rec_we,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rec_waddr,
  output logic [TAG_W+1+$clog2(SLOTS+1)-1:0]   rec_wdata,
  output logic                                 rec_re,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rec_raddr,
  input  logic [TAG_W+1+$clog2(SLOTS+1)-1:0]   rec_rdata,
  output logic                                 lnk_we,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] lnk_waddr,
  output logic [2*$clog2(SLOTS+1)-1:0]         lnk_wdata,
  output logic                                 lnk_re,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] lnk_raddr,
  input  logic [2*$clog2(SLOTS+1)-1:0]         lnk_rdata
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int RW = TAG_W + 1 + LW;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [LW+ACT_W-1:0] SLOTS_CMP = (LW + ACT_W)'(SLOTS);
  localparam logic [LW-1:0] N_RESET = (SLOTS < ACT_RESET) ? LW'(SLOTS) : LW'(ACT_RESET);

  function automatic logic [SLOT_W-1:0] slot_field(input logic [SW-1:0] s);
    logic [SW+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, s};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_field(input logic [LW-1:0] c);
    logic [LW+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, c};
    return w[CNT_W-1:0];
  endfunction

  // Control state.
  state_t            state_r, state_nxt;
  logic [LW-1:0]     n_act_r, n_act_nxt;
  logic [LW-1:0]     fresh_r, fresh_nxt;
  logic [LW-1:0]     rel_head_r, rel_head_nxt;
  logic [LW-1:0]     head_r, head_nxt;
  logic [LW-1:0]     tail_r, tail_nxt;
  logic [LW-1:0]     count_r, count_nxt;

  // Request payload held while it is worked on.
  logic              pre_r, pre_nxt;
  logic              canc_r, canc_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [HND_W-1:0]  hnd_r, hnd_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic              full_r, full_nxt;
  logic              ok_r, ok_nxt;
  logic [LW-1:0]     pl_r, pl_nxt;
  logic [LW-1:0]     nl_r, nl_nxt;

  logic              stack_any;
  logic              fresh_any;
  logic              list_empty;
  logic [LW+HND_W-1:0] hnd_wide;
  logic [SW+HND_W-1:0] hnd_idx_wide;
  logic [SW+HND_W-1:0] in_hnd_idx_wide;
  logic [LW+ACT_W-1:0] cfg_wide;
  logic [LW-1:0]     cnt_dec;
  logic [LW-1:0]     pop_next;
  logic              can_ok;
  logic [LW-1:0]     can_prev;
  logic [LW-1:0]     can_next;

  logic [TAG_W-1:0]  rd_tag;
  logic              rd_mark;
  logic [LW-1:0]     rd_free;
  logic [LW-1:0]     rd_prev;
  logic [LW-1:0]     rd_next;

  assign rd_tag  = rec_rdata[RW-1 -: TAG_W];
  assign rd_mark = rec_rdata[LW];
  assign rd_free = rec_rdata[LW-1:0];
  assign rd_prev = lnk_rdata[2*LW-1:LW];
  assign rd_next = lnk_rdata[LW-1:0];

  assign stack_any       = (rel_head_r != NIL);
  assign fresh_any       = (fresh_r < n_act_r);
  assign list_empty      = (head_r == NIL);
  assign hnd_wide        = {{LW{1'b0}}, hnd_r};
  assign hnd_idx_wide    = {{SW{1'b0}}, hnd_r};
  assign in_hnd_idx_wide = {{SW{1'b0}}, in_req.handle};
  assign cfg_wide        = {{LW{1'b0}}, cfg_wr_data};
  assign cnt_dec         = (count_r != '0) ? count_r - 1'b1 : count_r;
  assign pop_next        = (head_r == tail_r) ? NIL : rd_next;

  // A slot at or above the fill count was never handed out since the last rebuild,
  // so its mark is known to be clear without reading it.
  assign can_ok   = (hnd_wide < {{HND_W{1'b0}}, fresh_r}) && rd_mark;
  assign can_prev = (hnd_wide == {{HND_W{1'b0}}, head_r}) ? NIL : rd_prev;
  assign can_next = (hnd_wide == {{HND_W{1'b0}}, tail_r}) ? NIL : rd_next;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    n_act_nxt    = n_act_r;
    fresh_nxt    = fresh_r;
    rel_head_nxt = rel_head_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    pre_nxt      = pre_r;
    canc_nxt     = canc_r;
    tag_nxt      = tag_r;
    hnd_nxt      = hnd_r;
    s_nxt        = s_r;
    full_nxt     = full_r;
    ok_nxt       = ok_r;
    pl_nxt       = pl_r;
    nl_nxt       = nl_r;
    rec_we       = 1'b0;
    rec_waddr    = '0;
    rec_wdata    = '0;
    rec_re       = 1'b0;
    rec_raddr    = '0;
    lnk_we       = 1'b0;
    lnk_waddr    = '0;
    lnk_wdata    = '0;
    lnk_re       = 1'b0;
    lnk_raddr    = '0;
    res_valid    = 1'b0;
    res          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pre_nxt  = in_req.prepend;
          canc_nxt = in_req.cancellable;
          tag_nxt  = in_req.work_tag;
          hnd_nxt  = in_req.handle;
          case (in_req.req_type)
            REQ_SUBMIT: begin
              s_nxt    = stack_any ? rel_head_r[SW-1:0] : fresh_r[SW-1:0];
              full_nxt = !stack_any && !fresh_any;
              // The new slot's own links need no read: as new head only its
              // next matters, as new tail only its prev.
              if (stack_any || fresh_any) begin
                lnk_we    = 1'b1;
                lnk_waddr = s_nxt;
                lnk_wdata = {tail_r, head_r};
              end
              rec_re    = 1'b1;
              rec_raddr = s_nxt;
              lnk_re    = 1'b1;
              lnk_raddr = in_req.prepend ? head_r[SW-1:0] : tail_r[SW-1:0];
              state_nxt = S_SUB;
            end
            REQ_POP: begin
              rec_re    = 1'b1;
              rec_raddr = head_r[SW-1:0];
              lnk_re    = 1'b1;
              lnk_raddr = head_r[SW-1:0];
              state_nxt = S_POP;
            end
            REQ_CANCEL: begin
              rec_re    = 1'b1;
              rec_raddr = in_hnd_idx_wide[SW-1:0];
              lnk_re    = 1'b1;
              lnk_raddr = in_hnd_idx_wide[SW-1:0];
              state_nxt = S_CAN1;
            end
            default: begin
              state_nxt = S_NOP;
            end
          endcase
        end
      end

      S_SUB: begin
        res_valid         = 1'b1;
        res.status        = full_r ? STAT_FULL : STAT_OK;
        res.slot          = full_r ? '0 : slot_field(s_r);
        res.wake          = !full_r && list_empty;
        res.pending_count = full_r ? cnt_field(count_r) : cnt_field(count_r + 1'b1);
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (!full_r) begin
            rec_we    = 1'b1;
            rec_waddr = s_r;
            rec_wdata = {tag_r, canc_r, rd_free};
            if (!list_empty) begin
              lnk_we    = 1'b1;
              lnk_waddr = pre_r ? head_r[SW-1:0] : tail_r[SW-1:0];
              lnk_wdata = pre_r ? {LW'(s_r), rd_next} : {rd_prev, LW'(s_r)};
            end
            if (stack_any) begin
              rel_head_nxt = rd_free;
            end else begin
              fresh_nxt = fresh_r + 1'b1;
            end
            if (list_empty) begin
              head_nxt = LW'(s_r);
              tail_nxt = LW'(s_r);
            end else if (pre_r) begin
              head_nxt = LW'(s_r);
            end else begin
              tail_nxt = LW'(s_r);
            end
            count_nxt = count_r + 1'b1;
          end
        end
      end

      S_POP: begin
        res_valid         = 1'b1;
        res.status        = list_empty ? STAT_EMPTY : STAT_OK;
        res.slot          = list_empty ? '0 : slot_field(head_r[SW-1:0]);
        res.out_tag       = list_empty ? '0 : rd_tag;
        res.pending_count = list_empty ? cnt_field(count_r) : cnt_field(cnt_dec);
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (!list_empty) begin
            rec_we       = 1'b1;
            rec_waddr    = head_r[SW-1:0];
            rec_wdata    = {rd_tag, 1'b0, rel_head_r};
            rel_head_nxt = head_r;
            head_nxt     = pop_next;
            if (pop_next == NIL) begin
              tail_nxt = NIL;
            end
            count_nxt = cnt_dec;
          end
        end
      end

      S_CAN1: begin
        ok_nxt = can_ok;
        pl_nxt = can_prev;
        nl_nxt = can_next;
        if (can_ok) begin
          rec_we       = 1'b1;
          rec_waddr    = hnd_idx_wide[SW-1:0];
          rec_wdata    = {rd_tag, 1'b0, rel_head_r};
          rel_head_nxt = hnd_wide[LW-1:0];
          if (can_prev == NIL) begin
            head_nxt = can_next;
          end
          if (can_next == NIL) begin
            tail_nxt = can_prev;
          end
          count_nxt = cnt_dec;
          if (can_prev != NIL) begin
            lnk_re    = 1'b1;
            lnk_raddr = can_prev[SW-1:0];
          end
        end
        state_nxt = S_CAN2;
      end

      S_CAN2: begin
        if (ok_r && (pl_r != NIL)) begin
          lnk_we    = 1'b1;
          lnk_waddr = pl_r[SW-1:0];
          lnk_wdata = {rd_prev, nl_r};
        end
        if (ok_r && (nl_r != NIL)) begin
          lnk_re    = 1'b1;
          lnk_raddr = nl_r[SW-1:0];
        end
        state_nxt = S_CAN3;
      end

      S_CAN3: begin
        res_valid         = 1'b1;
        res.status        = ok_r ? STAT_OK : STAT_IGNORED;
        res.slot          = hnd_r;
        res.pending_count = cnt_field(count_r);
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (ok_r && (nl_r != NIL)) begin
            lnk_we    = 1'b1;
            lnk_waddr = nl_r[SW-1:0];
            lnk_wdata = {pl_r, rd_next};
          end
        end
      end

      S_NOP: begin
        res_valid         = 1'b1;
        res.status        = STAT_IGNORED;
        res.pending_count = cnt_field(count_r);
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A pool size write empties both lists; the fill count restarts at zero.
    if (cfg_wr_en) begin
      n_act_nxt    = (cfg_wide > SLOTS_CMP) ? NIL : cfg_wide[LW-1:0];
      fresh_nxt    = '0;
      rel_head_nxt = NIL;
      head_nxt     = NIL;
      tail_nxt     = NIL;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      n_act_r    <= N_RESET;
      fresh_r    <= '0;
      rel_head_r <= NIL;
      head_r     <= NIL;
      tail_r     <= NIL;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      n_act_r    <= n_act_nxt;
      fresh_r    <= fresh_nxt;
      rel_head_r <= rel_head_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_r  <= pre_nxt;
    canc_r <= canc_nxt;
    tag_r  <= tag_nxt;
    hnd_r  <= hnd_nxt;
    s_r    <= s_nxt;
    full_r <= full_nxt;
    ok_r   <= ok_nxt;
    pl_r   <= pl_nxt;
    nl_r   <= nl_nxt;
  end

endmodule

// File: sv/run_queue_slot_manager_unit.sv
// Top level of the run queue slot manager: stream ports, slot memories and result register.
//
// The block keeps a fixed pool of SLOTS work slots. A request on the in_ stream
// submits a work tag, cancels a pending slot by handle, or pops the head of the
// pending list; each request gives exactly one result on the out_ stream.
// in_tuser carries the request kind, in_tdata the remaining request fields.
// out_tuser carries the status, out_tdata the slot, tag, wake flag and count.
// Submit and pop read the slot's record and link entries in the accepting cycle;
// S_SUB or S_POP then writes them back and loads the result register, which
// drives out_tvalid. The unused request kind loads its result from S_NOP. A
// cancel passes through S_CAN1, S_CAN2 and S_CAN3, loading its result in S_CAN3,
// because it rewrites the link entries of both neighbors through the single
// write port of the link memory, one after the other.
// Requests are worked on one at a time; in_tready is high only while idle.
// The result sits in an output register, so a new request is taken while the
// previous result still waits; if out_tready stays low, the finishing request
// holds its write-back until the register frees up.
// Reset (and any cfg_wr_en write) empties both lists: a fill count
// hands out never-used slots in order, so the memories need no clearing pass.
// cfg_wr_data sets the number of slots in use, clamped to SLOTS.
module run_queue_slot_manager_unit
  import rqsm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [ACT_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // prepend[0], cancellable[1], work_tag[33:2], handle[37:34], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // slot[3:0], out_tag[35:4], wake[36], pending_count[41:37], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]     out_tuser
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int RW = TAG_W + 1 + LW;
  localparam int KW = 2 * LW;

  req_t          in_req;
  res_t          res;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r;

  logic          rec_we, rec_re;
  logic [SW-1:0] rec_waddr, rec_raddr;
  logic [RW-1:0] rec_wdata, rec_rdata;
  logic          lnk_we, lnk_re;
  logic [SW-1:0] lnk_waddr, lnk_raddr;
  logic [KW-1:0] lnk_wdata, lnk_rdata;

  assign in_req.req_type    = in_tuser;
  assign in_req.prepend     = in_tdata[0];
  assign in_req.cancellable = in_tdata[1];
  assign in_req.work_tag    = in_tdata[33:2];
  assign in_req.handle      = in_tdata[37:34];

  // The sequencer may finish a request whenever the result register is empty
  // or is being drained in this cycle.
  assign res_ready = !out_valid_r || out_tready;

  rqsm_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (in_req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rec_we      (rec_we),
    .rec_waddr   (rec_waddr),
    .rec_wdata   (rec_wdata),
    .rec_re      (rec_re),
    .rec_raddr   (rec_raddr),
    .rec_rdata   (rec_rdata),
    .lnk_we      (lnk_we),
    .lnk_waddr   (lnk_waddr),
    .lnk_wdata   (lnk_wdata),
    .lnk_re      (lnk_re),
    .lnk_raddr   (lnk_raddr),
    .lnk_rdata   (lnk_rdata)
  );

  // Per-slot record: work tag, cancel mark and free-stack link.
  rqsm_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  // Per-slot pending-list links: previous and next slot.
  rqsm_ram #(
    .WIDTH (KW),
    .DEPTH (SLOTS)
  ) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .re    (lnk_re),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'b0, out_res_r.pending_count, out_res_r.wake,
                       out_res_r.out_tag, out_res_r.slot};

endmodule
